FILE: sv/ifd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer package
// Shared types, codes and constants of the image frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

	// Receive phases of the frame parser; code 7 is unused and parses as magic.
	typedef enum logic [2:0] {
		PH_MAGIC     = 3'd0,
		PH_WIDTH     = 3'd1,
		PH_HEIGHT    = 3'd2,
		PH_LABEL_LEN = 3'd3,
		PH_LABEL     = 3'd4,
		PH_PIXELS    = 3'd5,
		PH_CHECKSUM  = 3'd6
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_LABEL  = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_REJECT = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PRINT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS   = 1'b1;

	localparam logic        AUTO_PRINT_RST = 1'b1;
	localparam logic [15:0] MAX_ROWS_RST   = 16'd800;

	// Frame start sequence "M5PV".
	localparam logic [7:0] MAGIC_FIRST = 8'h4D;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] val;
		case (idx)
			2'd0: val = 8'h4D;
			2'd1: val = 8'h35;
			2'd2: val = 8'h50;
			default: val = 8'h56;
		endcase
		return val;
	endfunction

	// One received byte waiting in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] column;
		logic [15:0] row_index;
		logic        sum_ok;
		logic        print_now;
		logic [7:0]  kept_label_len;
		logic [15:0] frame_rows;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} res_item_t;

endpackage

FILE: sv/ifd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer channels
// Valid/ready interfaces for the received byte stream and the result stream.
// ----------------------------------------------------------------------------
interface ifd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data;
	logic [15:0] column;
	logic [15:0] row_index;
	logic        sum_ok;
	logic        print_now;
	logic [7:0]  kept_label_len;
	logic [15:0] frame_rows;

	modport source (
		output valid, output kind, output data, output column, output row_index,
		output sum_ok, output print_now, output kept_label_len, output frame_rows,
		input ready
	);
	modport sink (
		input valid, input kind, input data, input column, input row_index,
		input sum_ok, input print_now, input kept_label_len, input frame_rows,
		output ready
	);
endinterface

FILE: sv/ifd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer input stage
// Registers one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module ifd_in_stage
	import ifd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ifd_in_if.sink    in_ch,
	input  logic      take,
	output in_item_t  item
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	assign advance     = valid_s1 && take;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.rx_byte;
		end
	end

	assign item.valid   = valid_s1;
	assign item.rx_byte = byte_s1;

endmodule

FILE: sv/ifd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer parser
// Frame state machine: magic search, header checks, label and pixel counting.
// ----------------------------------------------------------------------------
module ifd_parser
	import ifd_pkg::*;
#(
	parameter int ROW_BYTES = 384,
	parameter int LABEL_MAX = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              item,
	input  logic                  take,
	output res_item_t             result
);

	localparam int COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(ROW_BYTES - 1);
	localparam logic [15:0]      WIDTH_REQ = 16'(ROW_BYTES);
	localparam logic [7:0]       LABEL_CAP = 8'(LABEL_MAX);

	logic        auto_print_q;
	logic [15:0] max_rows_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  magic_cnt_q, magic_cnt_d;
	logic        hi_next_q, hi_next_d;
	logic [7:0]  width_lo_q, width_lo_d;
	logic        width_ok_q, width_ok_d;
	logic [15:0] height_q, height_d;
	logic [15:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [7:0]  wire_len_q, wire_len_d;
	logic [7:0]  keep_len_q, keep_len_d;
	logic [7:0]  label_cnt_q, label_cnt_d;
	logic [7:0]  sum_q, sum_d;

	logic        fire;
	logic [7:0]  b;
	logic [15:0] height_full;
	logic        header_bad;
	logic [7:0]  label_cnt_inc;
	logic [15:0] row_inc;
	logic        sum_match;

	assign fire          = item.valid && take;
	assign b             = item.rx_byte;
	assign height_full   = {b, height_q[7:0]};
	assign header_bad    = !width_ok_q || (height_full == 16'd0) || (height_full > max_rows_q);
	assign label_cnt_inc = label_cnt_q + 8'd1;
	assign row_inc       = row_q + 16'd1;
	assign sum_match     = (sum_q == b);

	// Next state.
	always_comb begin
		phase_d     = phase_q;
		magic_cnt_d = magic_cnt_q;
		hi_next_d   = hi_next_q;
		width_lo_d  = width_lo_q;
		width_ok_d  = width_ok_q;
		height_d    = height_q;
		row_d       = row_q;
		col_d       = col_q;
		wire_len_d  = wire_len_q;
		keep_len_d  = keep_len_q;
		label_cnt_d = label_cnt_q;
		sum_d       = sum_q;
		case (phase_q)
			PH_WIDTH: begin
				if (!hi_next_q) begin
					width_lo_d = b;
					hi_next_d  = 1'b1;
				end else begin
					width_ok_d = ({b, width_lo_q} == WIDTH_REQ);
					hi_next_d  = 1'b0;
					phase_d    = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				if (!hi_next_q) begin
					height_d  = {8'd0, b};
					hi_next_d = 1'b1;
				end else begin
					height_d  = height_full;
					hi_next_d = 1'b0;
					row_d     = 16'd0;
					col_d     = '0;
					if (header_bad) begin
						phase_d     = PH_MAGIC;
						magic_cnt_d = 2'd0;
					end else begin
						sum_d   = 8'd0;
						phase_d = PH_LABEL_LEN;
					end
				end
			end
			PH_LABEL_LEN: begin
				wire_len_d  = b;
				keep_len_d  = (b > LABEL_CAP) ? LABEL_CAP : b;
				label_cnt_d = 8'd0;
				phase_d     = (b == 8'd0) ? PH_PIXELS : PH_LABEL;
			end
			PH_LABEL: begin
				sum_d       = sum_q + b;
				label_cnt_d = label_cnt_inc;
				if (label_cnt_inc == wire_len_q) begin
					phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				sum_d = sum_q + b;
				if (col_q == COL_LAST) begin
					col_d = '0;
					row_d = row_inc;
					if (row_inc == height_q) begin
						phase_d = PH_CHECKSUM;
					end
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			PH_CHECKSUM: begin
				phase_d     = PH_MAGIC;
				magic_cnt_d = 2'd0;
				hi_next_d   = 1'b0;
				row_d       = 16'd0;
				col_d       = '0;
			end
			default: begin
				// Magic search; the unused phase code lands here as well.
				phase_d = PH_MAGIC;
				if (b == magic_byte(magic_cnt_q)) begin
					if (magic_cnt_q == 2'd3) begin
						magic_cnt_d = 2'd0;
						hi_next_d   = 1'b0;
						phase_d     = PH_WIDTH;
					end else begin
						magic_cnt_d = magic_cnt_q + 2'd1;
					end
				end else begin
					magic_cnt_d = (b == MAGIC_FIRST) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

	// Result of the byte being parsed.
	always_comb begin
		result     = '0;
		result.res.kind = KIND_LABEL;
		case (phase_q)
			PH_HEIGHT: begin
				if (hi_next_q && header_bad) begin
					result.valid    = fire;
					result.res.kind = KIND_REJECT;
				end
			end
			PH_LABEL: begin
				if (label_cnt_q < keep_len_q) begin
					result.valid      = fire;
					result.res.kind   = KIND_LABEL;
					result.res.data   = b;
					result.res.column = {8'd0, label_cnt_q};
				end
			end
			PH_PIXELS: begin
				result.valid         = fire;
				result.res.kind      = KIND_PIXEL;
				result.res.data      = b;
				result.res.column    = 16'(col_q);
				result.res.row_index = row_q;
			end
			PH_CHECKSUM: begin
				result.valid              = fire;
				result.res.kind           = KIND_DONE;
				result.res.sum_ok         = sum_match;
				result.res.print_now      = sum_match && auto_print_q;
				result.res.kept_label_len = keep_len_q;
				result.res.frame_rows     = height_q;
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_print_q <= AUTO_PRINT_RST;
			max_rows_q   <= MAX_ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AUTO_PRINT: auto_print_q <= cfg_data[0];
				CFG_MAX_ROWS:   max_rows_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			magic_cnt_q <= 2'd0;
			hi_next_q   <= 1'b0;
			width_lo_q  <= 8'd0;
			width_ok_q  <= 1'b0;
			height_q    <= 16'd0;
			row_q       <= 16'd0;
			col_q       <= '0;
			wire_len_q  <= 8'd0;
			keep_len_q  <= 8'd0;
			label_cnt_q <= 8'd0;
			sum_q       <= 8'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			magic_cnt_q <= magic_cnt_d;
			hi_next_q   <= hi_next_d;
			width_lo_q  <= width_lo_d;
			width_ok_q  <= width_ok_d;
			height_q    <= height_d;
			row_q       <= row_d;
			col_q       <= col_d;
			wire_len_q  <= wire_len_d;
			keep_len_q  <= keep_len_d;
			label_cnt_q <= label_cnt_d;
			sum_q       <= sum_d;
		end
	end

	// A rejected header always sends the parser back to the magic search.
	a_reject_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.res.kind == KIND_REJECT) |=> (phase_q == PH_MAGIC))
		else $error("parser did not restart after a rejected header");

	// Pixel rows never run past the frame height.
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (row_q < height_q))
		else $error("pixel row beyond frame height");

	// The label phase is only entered with a nonzero label length.
	a_label_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LABEL) |-> (wire_len_q != 8'd0))
		else $error("label phase with an empty label");

endmodule

FILE: sv/ifd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer output buffer
// Two-entry result queue that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module ifd_out_buf
	import ifd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_item_t result,
	output logic      take,
	ifd_out_if.source out_ch
);

	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	res_t       head;

	assign take = (cnt_q != 2'd2);
	assign push = result.valid;
	assign pop  = out_ch.valid && out_ch.ready;
	assign head = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= result.res;
		end
	end

	assign out_ch.valid          = (cnt_q != 2'd0);
	assign out_ch.kind           = head.kind;
	assign out_ch.data           = head.data;
	assign out_ch.column         = head.column;
	assign out_ch.row_index      = head.row_index;
	assign out_ch.sum_ok         = head.sum_ok;
	assign out_ch.print_now      = head.print_now;
	assign out_ch.kept_label_len = head.kept_label_len;
	assign out_ch.frame_rows     = head.frame_rows;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == 2'd2) |-> pop)
		else $error("result pushed into a full queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

FILE: sv/image_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer
// Parses "M5PV" image frames from a received byte stream and emits label
// bytes, pixel bytes, header rejects and frame-complete reports.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Payload
//   in_ch     in         valid / ready   rx_byte
//   out_ch    out        valid / ready   kind, data, column, row_index, sum_ok,
//                                        print_now, kept_label_len, frame_rows
//   cfg       in         cfg_we          cfg_index, cfg_data
//
// While the output queue has room, one byte is accepted per cycle. An
// accepted byte is parsed while it sits in the input register; its result,
// if any, enters a two-entry output queue at the edge where the parser takes
// the byte, and is offered on out_ch once it reaches the head of the queue.
// Reset sets the parser to the magic search, auto print on and max rows 800.
// A stalled output fills the queue; once both entries are full the parser
// holds its byte and the input ready drops until a result is taken.
//
module image_frame_deframer
	import ifd_pkg::*;
#(
	parameter int ROW_BYTES = 384,
	parameter int LABEL_MAX = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ifd_in_if.sink                in_ch,
	ifd_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Byte held in the input register, and the parser's result toward the queue.
	in_item_t  item;
	res_item_t result;
	// High while the output queue has room for a result.
	logic      take;

	ifd_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.take   (take),
		.item   (item)
	);

	// The parser advances on every transaction out of the input register,
	// whether or not that byte produces a result.
	ifd_parser #(
		.ROW_BYTES (ROW_BYTES),
		.LABEL_MAX (LABEL_MAX)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.take      (take),
		.result    (result)
	);

	ifd_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.result (result),
		.take   (take),
		.out_ch (out_ch)
	);

endmodule

FILE: bench/ifd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer checker
// Follows every received byte with its own frame parser, queues the report
// each byte should cause and compares the result stream against that queue.
// ----------------------------------------------------------------------------
module ifd_frame_checker
	import ifd_pkg::*;
#(
	parameter int ROW_BYTES = 384,
	parameter int LABEL_MAX = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ifd_in_if                     in_mon,
	ifd_out_if                    out_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    reports_due,
	output int                    n_labels,
	output int                    n_pixels,
	output int                    n_rejects,
	output int                    n_frames,
	output int                    n_good_sums
);

	localparam logic [31:0] FRAME_MAGIC = 32'h4D35_5056;
	localparam logic [15:0] ROW_W16     = 16'(ROW_BYTES);
	localparam logic [7:0]  KEEP_MAX    = 8'(LABEL_MAX);

	// Register copies.
	logic        cfg_auto;
	logic [15:0] cfg_max_rows;

	// Parser state.
	phase_t      cur_phase;
	logic [2:0]  magic_hits;
	logic        want_high;
	logic [15:0] hdr_width;
	logic [15:0] hdr_height;
	logic [15:0] pix_row;
	logic [15:0] pix_col;
	logic [7:0]  lbl_wire;
	logic [7:0]  lbl_keep;
	logic [7:0]  lbl_seen;
	logic [7:0]  byte_sum;

	res_t parsed_q[$];

	task automatic restart_hunt();
		cur_phase  = PH_MAGIC;
		magic_hits = '0;
		want_high  = 1'b0;
		pix_row    = '0;
		pix_col    = '0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b);
		res_t r;
		r = '0;
		case (cur_phase)
			PH_WIDTH: begin
				if (!want_high) begin
					hdr_width = {8'h00, b};
					want_high = 1'b1;
				end else begin
					hdr_width[15:8] = b;
					want_high = 1'b0;
					cur_phase = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				if (!want_high) begin
					hdr_height = {8'h00, b};
					want_high  = 1'b1;
				end else begin
					hdr_height[15:8] = b;
					want_high = 1'b0;
					if (hdr_width != ROW_W16 || hdr_height == 16'd0 ||
							hdr_height > cfg_max_rows) begin
						restart_hunt();
						r.kind = KIND_REJECT;
						parsed_q.push_back(r);
						n_rejects++;
					end else begin
						pix_row   = '0;
						pix_col   = '0;
						byte_sum  = '0;
						cur_phase = PH_LABEL_LEN;
					end
				end
			end
			PH_LABEL_LEN: begin
				lbl_wire  = b;
				lbl_keep  = (b > KEEP_MAX) ? KEEP_MAX : b;
				lbl_seen  = '0;
				cur_phase = (b == 8'd0) ? PH_PIXELS : PH_LABEL;
			end
			PH_LABEL: begin
				if (lbl_seen < lbl_keep) begin
					r.kind   = KIND_LABEL;
					r.data   = b;
					r.column = {8'h00, lbl_seen};
					parsed_q.push_back(r);
					n_labels++;
				end
				byte_sum = byte_sum + b;
				lbl_seen = lbl_seen + 8'd1;
				if (lbl_seen == lbl_wire)
					cur_phase = PH_PIXELS;
			end
			PH_PIXELS: begin
				r.kind      = KIND_PIXEL;
				r.data      = b;
				r.column    = pix_col;
				r.row_index = pix_row;
				parsed_q.push_back(r);
				n_pixels++;
				byte_sum = byte_sum + b;
				pix_col  = pix_col + 16'd1;
				if (pix_col == hdr_width) begin
					pix_col = '0;
					pix_row = pix_row + 16'd1;
					if (pix_row == hdr_height)
						cur_phase = PH_CHECKSUM;
				end
			end
			PH_CHECKSUM: begin
				r.kind           = KIND_DONE;
				r.sum_ok         = (byte_sum == b);
				r.print_now      = r.sum_ok && cfg_auto;
				r.kept_label_len = lbl_keep;
				r.frame_rows     = hdr_height;
				parsed_q.push_back(r);
				n_frames++;
				if (r.sum_ok)
					n_good_sums++;
				restart_hunt();
			end
			default: begin
				// Hunting for the magic; a miss only restarts on a fresh 'M'.
				if (b == FRAME_MAGIC[31 - 8 * magic_hits[1:0] -: 8]) begin
					magic_hits = magic_hits + 3'd1;
					if (magic_hits == 3'd4) begin
						magic_hits = '0;
						want_high  = 1'b0;
						cur_phase  = PH_WIDTH;
					end
				end else begin
					magic_hits = (b == FRAME_MAGIC[31:24]) ? 3'd1 : 3'd0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			cfg_auto     = AUTO_PRINT_RST;
			cfg_max_rows = MAX_ROWS_RST;
			restart_hunt();
			hdr_width    = '0;
			hdr_height   = '0;
			lbl_wire     = '0;
			lbl_keep     = '0;
			lbl_seen     = '0;
			byte_sum     = '0;
			parsed_q.delete();
			reports_due  = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (parsed_q.size() == 0) begin
					$error("Result transaction with no report outstanding: kind %0d",
						out_mon.kind);
					fail_count++;
				end else begin
					want = parsed_q.pop_front();
					check_field("kind", want.kind, out_mon.kind);
					check_field("data", want.data, out_mon.data);
					check_field("column", want.column, out_mon.column);
					check_field("row_index", want.row_index, out_mon.row_index);
					check_field("sum_ok", want.sum_ok, out_mon.sum_ok);
					check_field("print_now", want.print_now, out_mon.print_now);
					check_field("kept_label_len", want.kept_label_len,
						out_mon.kept_label_len);
					check_field("frame_rows", want.frame_rows, out_mon.frame_rows);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_AUTO_PRINT: cfg_auto = cfg_data[0];
					CFG_MAX_ROWS:   cfg_max_rows = cfg_data;
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				parse_rx_byte(in_mon.rx_byte);
			reports_due = parsed_q.size();
		end
	end

endmodule

FILE: bench/tb_image_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame deframer testbench
// Feeds the deframer directed header cases and then random streams of good,
// rejected, broken and noisy frames under four register settings and four
// idling patterns; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_image_frame_deframer;
	import ifd_pkg::*;

	localparam int ROW_BYTES = 384;
	localparam int LABEL_MAX = 32;
	localparam logic [15:0] ROW_W16 = 16'(ROW_BYTES);

	// A byte passes the input register and the block buffers two results, so a
	// handful of quiet cycles is enough for a byte with no result to clear.
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ifd_in_if  in_ch ();
	ifd_out_if out_ch ();

	int fail_count;
	int reports_due;
	int n_labels;
	int n_pixels;
	int n_rejects;
	int n_frames;
	int n_good_sums;

	// Stimulus bookkeeping.
	int          sent_bytes = 0;
	int          frame_seq = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	logic [15:0] cur_max_rows = MAX_ROWS_RST;

	always #1 clk = ~clk;

	image_frame_deframer #(
		.ROW_BYTES(ROW_BYTES),
		.LABEL_MAX(LABEL_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	ifd_frame_checker #(
		.ROW_BYTES(ROW_BYTES),
		.LABEL_MAX(LABEL_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.reports_due(reports_due),
		.n_labels   (n_labels),
		.n_pixels   (n_pixels),
		.n_rejects  (n_rejects),
		.n_frames   (n_frames),
		.n_good_sums(n_good_sums)
	);

	// The result side stalls at random; stall_pct of zero keeps ready high.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one byte and returns at the edge where the transaction happens.
	// Before the byte the sender keeps idling while a draw with chance gap_pct
	// comes up, so about that share of its cycles is idle. Ready is looked at
	// on the falling edge, where it has settled for the coming rising edge.
	// Valid stays high on return so back-to-back bytes never drop it.
	task automatic send_byte(input logic [7:0] b);
		logic rdy;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= b;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		sent_bytes++;
	endtask

	// Holds the sender back until every predicted report has arrived and the
	// parser has had time to swallow any byte that causes no report.
	task automatic drain_parser();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (reports_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers while the block is idle. Writes go on adjacent
	// edges so the write enable is raised and lowered exactly once.
	task automatic write_regs(input logic auto_on, input logic [15:0] rows_max);
		drain_parser();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_AUTO_PRINT;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, auto_on};
		@(posedge clk);
		cfg_index <= CFG_MAX_ROWS;
		cfg_data  <= rows_max;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max_rows = rows_max;
	endtask

	// Magic followed by little-endian width and height.
	task automatic send_header(input logic [15:0] w, input logic [15:0] h);
		int i;
		for (i = 0; i < 4; i++)
			send_byte(magic_byte(2'(i)));
		send_byte(w[7:0]);
		send_byte(w[15:8]);
		send_byte(h[7:0]);
		send_byte(h[15:8]);
	endtask

	// A complete, well-formed one-row frame. Label lengths cycle through
	// empty, over the keep limit and short, and the third frame of each
	// round carries a corrupted checksum.
	task automatic send_good_frame();
		logic [7:0]  sum;
		logic [7:0]  b;
		int          lbl_len;
		int          i;
		case (frame_seq % 3)
			0: lbl_len = 0;
			1: lbl_len = $urandom_range(LABEL_MAX + 1, LABEL_MAX + 32);
			default: lbl_len = $urandom_range(1, LABEL_MAX);
		endcase
		send_header(ROW_W16, 16'd1);
		send_byte(8'(lbl_len));
		sum = '0;
		for (i = 0; i < lbl_len + ROW_BYTES; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		if (frame_seq % 3 == 2)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
		frame_seq++;
	endtask

	// A header that must be rejected: wrong width, zero height or a height
	// above the current row limit.
	task automatic send_bad_header();
		case ($urandom_range(2))
			0: send_header(ROW_W16 ^ 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 3)));
			1: send_header(ROW_W16, 16'd0);
			default: begin
				if (cur_max_rows != 16'hFFFF)
					send_header(ROW_W16,
						16'($urandom_range(int'(cur_max_rows) + 1, 65535)));
				else
					send_header(16'($urandom), 16'd0);
			end
		endcase
	endtask

	// Random bytes with a good share of 'M' to exercise the restart rule.
	task automatic send_noise();
		int n;
		int i;
		n = $urandom_range(1, 12);
		for (i = 0; i < n; i++)
			send_byte(($urandom_range(3) == 0) ? MAGIC_FIRST : 8'($urandom));
	endtask

	// Either a magic that breaks off part way, or a one-row frame cut short in
	// its label or pixels so that whatever follows is parsed as frame body.
	task automatic send_broken();
		int k;
		int i;
		if ($urandom_range(1) == 0) begin
			k = $urandom_range(1, 3);
			for (i = 0; i < k; i++)
				send_byte(magic_byte(2'(i)));
			send_byte(8'($urandom));
		end else begin
			send_header(ROW_W16, 16'd1);
			send_byte(8'($urandom_range(0, 40)));
			k = $urandom_range(0, 60);
			for (i = 0; i < k; i++)
				send_byte(8'($urandom));
		end
	endtask

	// Random traffic that includes well-formed frames until min_frames of them
	// have gone out, then only rejected headers, noise, broken sequences and the
	// occasional full drain of the block until min_bytes have been sent.
	task automatic run_traffic(input int min_bytes, input int min_frames);
		int start_bytes;
		int frames;
		int pick;
		start_bytes = sent_bytes;
		frames = 0;
		while (sent_bytes - start_bytes < min_bytes || frames < min_frames) begin
			pick = (frames < min_frames) ? $urandom_range(99) : $urandom_range(45, 99);
			if (pick < 45) begin
				send_good_frame();
				frames++;
			end else if (pick < 62) begin
				send_bad_header();
			end else if (pick < 77) begin
				send_noise();
			end else if (pick < 90) begin
				send_broken();
			end else begin
				drain_parser();
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.rx_byte <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_AUTO_PRINT;
		cfg_data      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed header cases under the reset settings. An extra 'M' ahead of
		// the magic is absorbed by the restart rule; the zero height rejects.
		send_byte(MAGIC_FIRST);
		send_header(ROW_W16, 16'd0);
		// A magic that breaks after "M5" and restarts on the next 'M', then an
		// all-ones width that rejects.
		send_byte(magic_byte(2'd0));
		send_byte(magic_byte(2'd1));
		send_header(16'hFFFF, 16'd1);
		// One row over the reset row limit.
		send_header(ROW_W16, cur_max_rows + 16'd1);
		drain_parser();

		// Reset settings, no idling on either side.
		gap_pct   = 0;
		stall_pct = 0;
		run_traffic(200, 1);

		// Preview mode with the smallest row limit; the sender idles.
		write_regs(1'b0, 16'd1);
		gap_pct   = 73;
		stall_pct = 0;
		run_traffic(200, 1);

		// Auto print with the largest row limit; the receiver stalls.
		write_regs(1'b1, 16'hFFFF);
		gap_pct   = 0;
		stall_pct = 73;
		run_traffic(200, 1);

		// Preview mode with two rows allowed; both sides idle now and then.
		write_regs(1'b0, 16'd2);
		gap_pct   = 14;
		stall_pct = 14;
		run_traffic(80, 0);

		drain_parser();
		$display("Sent %0d bytes under four register settings and four idling patterns.",
			sent_bytes);
		$display("Checked %0d frames (%0d good sums), %0d rejects, %0d labels, %0d pixels.",
			n_frames, n_good_sums, n_rejects, n_labels, n_pixels);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
